>>> hdl/assert_macros.svh
// Assertion macros shared by the accelerometer averaging block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on clk_i, switched off while rst_ni is low
`define TAMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tama assertion failed");
// Checked on clk_i at every edge, reset included
`define TAMA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("tama assertion failed");
`else
`define TAMA_ASSERT(lbl, prop)
`define TAMA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hdl/tama_pkg.sv
// Types and constants of the three-axis accelerometer moving average
package tama_pkg;

  // Input bytes and decoded raw sample
  localparam int ByteW      = 8;
  localparam int RawW       = 10;
  // Scaling: sample * 10000 >>> 6
  localparam int ScaleW     = 15;
  localparam logic signed [ScaleW-1:0] ScaleMul = 15'sd10000;
  localparam int ScaleShift = 6;
  localparam int ProdW      = RawW + ScaleW;
  localparam int SampleW    = 18;

  // Filter geometry
  localparam int FilterDepth = 8;
  localparam int FilterShift = 3;
  localparam int SlotW       = (FilterDepth > 1) ? $clog2(FilterDepth) : 1;
  localparam int CntW        = $clog2(FilterDepth + 1);
  localparam int SumW        = SampleW - FilterShift + SlotW + 1;

  // Configuration and result widths
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;
  localparam int OutW     = 19;
  localparam int CalcW    = ((SumW > CfgDataW) ? SumW : CfgDataW) + 2;

  // Queue between decode and filter
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegOffsetX = 2'd0,
    RegOffsetY = 2'd1,
    RegOffsetZ = 2'd2
  } reg_idx_e;

  // One scaled three-axis sample
  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] y;
    logic signed [SampleW-1:0] z;
  } axes_t;

  // Queue status seen by its neighbours
  typedef struct packed {
    logic push_ready;
    logic pop_valid;
  } fifo_stat_t;

endpackage

>>> hdl/tama_if.sv
// Channel interfaces: sample input, result output, configuration write
interface tama_in_if;
  logic                        valid;
  logic                        ready;
  logic [tama_pkg::ByteW-1:0]  pair0_low;
  logic [tama_pkg::ByteW-1:0]  pair0_high;
  logic [tama_pkg::ByteW-1:0]  pair1_low;
  logic [tama_pkg::ByteW-1:0]  pair1_high;
  logic [tama_pkg::ByteW-1:0]  pair2_low;
  logic [tama_pkg::ByteW-1:0]  pair2_high;

  modport source (output valid, pair0_low, pair0_high, pair1_low, pair1_high,
                  pair2_low, pair2_high, input ready);
  modport sink   (input valid, pair0_low, pair0_high, pair1_low, pair1_high,
                  pair2_low, pair2_high, output ready);
endinterface

interface tama_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tama_pkg::OutW-1:0]  accel_x;
  logic signed [tama_pkg::OutW-1:0]  accel_y;
  logic signed [tama_pkg::OutW-1:0]  accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tama_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tama_pkg::CfgIdxW-1:0]   index;
  logic [tama_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/three_axis_accel_moving_average.sv
// Top level of the three-axis accelerometer moving-average filter
//
//   Channel  Dir  Transfer payload
//   in_i     in   pair0..2 low/high bytes (Y, X, Z)
//   out_o    out  accel_x, accel_y, accel_z (19-bit signed)
//   cfg_i    in   index 0..2 = offset_x/y/z, 18-bit data
//
// One item a cycle sustained while out_o is ready; a transfer is held first in
// the decode queue register, and its result then in the result register.
// Running sums per axis replace the ring sum, so each item costs one add stage.
// Reset clears rings, sums, slot, fill count and offsets at once; no sweep.
// A stalled output holds the filter; the two-entry queue keeps input open.
module three_axis_accel_moving_average (
  input  logic       clk_i,
  input  logic       rst_ni,
  tama_in_if.sink    in_i,
  tama_out_if.source out_o,
  tama_cfg_if.sink   cfg_i
);

  tama_pkg::fifo_stat_t fifo_stat;
  tama_pkg::axes_t      push_data, pop_data;
  logic                 push_valid, pop_ready;

  tama_front u_front (
    .in_i         (in_i),
    .stat_i       (fifo_stat),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  tama_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .stat_o       (fifo_stat)
  );

  tama_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (fifo_stat),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_i),
    .out_o       (out_o)
  );

endmodule

>>> hdl/tama_front.sv
// Front end: takes six-byte reads and decodes them into scaled axis samples
module tama_front (
  tama_in_if.sink              in_i,
  input  tama_pkg::fifo_stat_t stat_i,
  output logic                 push_valid_o,
  output tama_pkg::axes_t      push_data_o
);

  logic signed [tama_pkg::RawW-1:0]  raw_x, raw_y, raw_z;
  logic signed [tama_pkg::ProdW-1:0] prod_x, prod_y, prod_z;

  // Ten-bit sample: signed high byte times four plus low byte bits 7:6
  assign raw_y = $signed({in_i.pair0_high, in_i.pair0_low[7:6]});
  assign raw_x = $signed({in_i.pair1_high, in_i.pair1_low[7:6]});
  assign raw_z = $signed({in_i.pair2_high, in_i.pair2_low[7:6]});

  // Scale by 10000, floor shift by taking the upper bits
  assign prod_x = tama_pkg::ProdW'(raw_x) * tama_pkg::ProdW'(tama_pkg::ScaleMul);
  assign prod_y = tama_pkg::ProdW'(raw_y) * tama_pkg::ProdW'(tama_pkg::ScaleMul);
  assign prod_z = tama_pkg::ProdW'(raw_z) * tama_pkg::ProdW'(tama_pkg::ScaleMul);

  assign push_data_o.x = prod_x[tama_pkg::ScaleShift +: tama_pkg::SampleW];
  assign push_data_o.y = prod_y[tama_pkg::ScaleShift +: tama_pkg::SampleW];
  assign push_data_o.z = prod_z[tama_pkg::ScaleShift +: tama_pkg::SampleW];

  // Transfer goes straight into the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = stat_i.push_ready;

endmodule

>>> hdl/tama_fifo.sv
// Short queue of decoded samples between front end and filter
module tama_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  tama_pkg::axes_t      push_data_i,
  input  logic                 pop_ready_i,
  output tama_pkg::axes_t      pop_data_o,
  output tama_pkg::fifo_stat_t stat_o
);

  tama_pkg::axes_t                mem_q [tama_pkg::FifoDepth];
  logic [tama_pkg::FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tama_pkg::FifoCntW-1:0]  count_q, count_d;
  logic                           push, pop;

  assign stat_o.push_ready = (count_q != tama_pkg::FifoCntW'(tama_pkg::FifoDepth));
  assign stat_o.pop_valid  = (count_q != '0);
  assign push = push_valid_i && stat_o.push_ready;
  assign pop  = pop_ready_i && stat_o.pop_valid;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tama_pkg::FifoPtrW'(tama_pkg::FifoDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tama_pkg::FifoPtrW'(tama_pkg::FifoDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/tama_back.sv
// Back end: sample rings, running sums, offsets and the result register
`include "assert_macros.svh"

module tama_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tama_pkg::fifo_stat_t stat_i,
  input  tama_pkg::axes_t      pop_data_i,
  output logic                 pop_ready_o,
  tama_cfg_if.sink             cfg_i,
  tama_out_if.source           out_o
);

  localparam int SumW  = tama_pkg::SumW;
  localparam int CalcW = tama_pkg::CalcW;
  localparam int OutW  = tama_pkg::OutW;

  tama_pkg::axes_t                  ring_q [tama_pkg::FilterDepth];
  tama_pkg::axes_t                  old_s;
  logic [tama_pkg::SlotW-1:0]       slot_q, slot_d;
  logic [tama_pkg::CntW-1:0]        fill_q, fill_d;
  logic signed [SumW-1:0]           sum_x_q, sum_y_q, sum_z_q;
  logic signed [SumW-1:0]           sum_x_d, sum_y_d, sum_z_d;
  logic signed [tama_pkg::CfgDataW-1:0] off_x_q, off_y_q, off_z_q;
  logic signed [CalcW-1:0]          res_x, res_y, res_z;
  logic                             out_valid_q, out_valid_d;
  logic [OutW-1:0]                  acc_x_q, acc_y_q, acc_z_q;
  logic                             advance, full_next;

  // Pop when the result register is empty or being drained
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign advance     = pop_ready_o && stat_i.pop_valid;

  // Entry being replaced this transfer
  assign old_s = ring_q[slot_q];

  // Running sums: add the new shifted sample, drop the one it replaces
  always_comb begin
    sum_x_d = sum_x_q + SumW'($signed(pop_data_i.x) >>> tama_pkg::FilterShift)
                      - SumW'($signed(old_s.x) >>> tama_pkg::FilterShift);
    sum_y_d = sum_y_q + SumW'($signed(pop_data_i.y) >>> tama_pkg::FilterShift)
                      - SumW'($signed(old_s.y) >>> tama_pkg::FilterShift);
    sum_z_d = sum_z_q + SumW'($signed(pop_data_i.z) >>> tama_pkg::FilterShift)
                      - SumW'($signed(old_s.z) >>> tama_pkg::FilterShift);
  end

  // Slot wrap and saturating fill count
  always_comb begin
    slot_d = (slot_q == tama_pkg::SlotW'(tama_pkg::FilterDepth - 1)) ?
             '0 : slot_q + 1'b1;
    fill_d = (fill_q < tama_pkg::CntW'(tama_pkg::FilterDepth)) ?
             fill_q + 1'b1 : fill_q;
    full_next = (fill_d == tama_pkg::CntW'(tama_pkg::FilterDepth));
  end

  // Offsets; Y average is negated first
  always_comb begin
    res_x = CalcW'(sum_x_d) - CalcW'(off_x_q);
    res_y = -CalcW'(sum_y_d) - CalcW'(off_y_q);
    res_z = CalcW'(sum_z_d) - CalcW'(off_z_q);
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && full_next) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tama_pkg::FilterDepth; i++) begin
        ring_q[i] <= '0;
      end
      slot_q      <= '0;
      fill_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        ring_q[slot_q] <= pop_data_i;
        slot_q  <= slot_d;
        fill_q  <= fill_d;
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        sum_z_q <= sum_z_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && full_next) begin
      acc_x_q <= res_x[OutW-1:0];
      acc_y_q <= res_y[OutW-1:0];
      acc_z_q <= res_z[OutW-1:0];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.accel_x = $signed(acc_x_q);
  assign out_o.accel_y = $signed(acc_y_q);
  assign out_o.accel_z = $signed(acc_z_q);

  // Configuration writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (tama_pkg::reg_idx_e'(cfg_i.index))
        tama_pkg::RegOffsetX: off_x_q <= $signed(cfg_i.data);
        tama_pkg::RegOffsetY: off_y_q <= $signed(cfg_i.data);
        tama_pkg::RegOffsetZ: off_z_q <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Checks
  `TAMA_ASSERT(a_fill_bound, fill_q <= tama_pkg::CntW'(tama_pkg::FilterDepth))
  `TAMA_ASSERT(a_slot_tracks_fill,
               (fill_q < tama_pkg::CntW'(tama_pkg::FilterDepth)) |->
               (tama_pkg::CntW'(slot_q) == fill_q))
  `TAMA_ASSERT(a_result_from_pop, $rose(out_valid_q) |-> $past(advance))
  `TAMA_ASSERT(a_no_result_filling,
               (fill_q < tama_pkg::CntW'(tama_pkg::FilterDepth)) |-> !out_valid_q)

endmodule
